### sv/iir_filter_tdf2_top_assert.svh
// Assertion macros shared by the checker of the IIR filter block.
`ifndef IIR_FILTER_TDF2_TOP_ASSERT_SVH
`define IIR_FILTER_TDF2_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IIRT2_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IIRT2_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/iirt2_pkg.sv
// Types and constants shared by the IIR filter controller, datapath and top level.
package iirt2_pkg;

    // Field widths
    localparam int X_W      = 16;
    localparam int ST_W     = 48;
    localparam int COEF_W   = 32;
    localparam int PROD_W   = 48;
    localparam int ACC_W    = 50;
    localparam int FRAC_W   = 28;
    localparam int OP_W     = 2;
    localparam int IDX_W    = 2;
    localparam int CIDX_W   = 3;
    localparam int CFG_IDX_W = 3;

    // Stream packing
    localparam int IN_X_LSB     = 0;
    localparam int IN_IDX_LSB   = IN_X_LSB + X_W;
    localparam int IN_SV_LSB    = IN_IDX_LSB + IDX_W;
    localparam int IN_TDATA_W   = ((IN_SV_LSB + ST_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((X_W + ST_W + 7) / 8) * 8;

    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;

    // Operation codes carried in tuser
    localparam logic [OP_W-1:0] OP_FILTER = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_A1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_A2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_A3 = 3'd6;

    localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sh1000_0000;

    // Rounding and clipping limits
    localparam t_acc RND_HALF = t_acc'(64'd1 << (FRAC_W - 1));
    localparam t_acc Y_MAX    = t_acc'(16'sh7FFF);
    localparam t_acc Y_MIN    = t_acc'(16'sh8000);
    localparam t_acc ST_MAX   = t_acc'(48'sh7FFF_FFFF_FFFF);
    localparam t_acc ST_MIN   = t_acc'(48'sh8000_0000_0000);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STATE_OP,
        ST_Y_MUL,
        ST_Y_ADD,
        ST_Y_RND,
        ST_ADD_B,
        ST_SUB_A,
        ST_WR_Z,
        ST_DONE
    } t_ctrl_state;

    typedef enum logic {
        MUL_B,
        MUL_A
    } t_mul_src;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_Z,
        ACC_LOAD_Z_ADD,
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

    typedef struct packed {
        logic                load;
        logic                state_op;
        t_mul_src            mul_src;
        logic [CIDX_W-1:0]   coef_idx;
        t_acc_op             acc_op;
        logic [CIDX_W-1:0]   z_idx;
        logic                z_wr;
        logic [IDX_W-1:0]    z_wr_idx;
        logic                y_latch;
        logic                out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

### sv/iirt2_ctrl.sv
// Sequencing state machine of the IIR filter: steps the shared multiplier and accumulator.
module iirt2_ctrl #(
    parameter int ORDER = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [iirt2_pkg::OP_W-1:0]    i_op,
    output logic                          o_in_ready,
    output iirt2_pkg::t_dp_cmd            o_cmd,
    input  iirt2_pkg::t_dp_status         i_status
);

    iirt2_pkg::t_ctrl_state r_state, n_state;
    logic [iirt2_pkg::IDX_W-1:0] r_k, n_k;
    logic w_last;

    assign w_last = (int'(r_k) == ORDER - 1);

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iirt2_pkg::ST_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            iirt2_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_op == iirt2_pkg::OP_FILTER) ? iirt2_pkg::ST_Y_MUL
                                                             : iirt2_pkg::ST_STATE_OP;
                end
            end
            iirt2_pkg::ST_STATE_OP: n_state = iirt2_pkg::ST_DONE;
            iirt2_pkg::ST_Y_MUL:    n_state = iirt2_pkg::ST_Y_ADD;
            iirt2_pkg::ST_Y_ADD:    n_state = iirt2_pkg::ST_Y_RND;
            iirt2_pkg::ST_Y_RND:    n_state = iirt2_pkg::ST_ADD_B;
            iirt2_pkg::ST_ADD_B:    n_state = iirt2_pkg::ST_SUB_A;
            iirt2_pkg::ST_SUB_A:    n_state = iirt2_pkg::ST_WR_Z;
            iirt2_pkg::ST_WR_Z: begin
                n_state = w_last ? iirt2_pkg::ST_DONE : iirt2_pkg::ST_SUB_A;
            end
            iirt2_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = iirt2_pkg::ST_IDLE;
                end
            end
            default: n_state = iirt2_pkg::ST_IDLE;
        endcase
    end

    // Step the state index: clear per item, bump after each state write but the last
    always_comb begin
        n_k = r_k;
        if (r_state == iirt2_pkg::ST_IDLE) begin
            n_k = '0;
        end else if (r_state == iirt2_pkg::ST_WR_Z && !w_last) begin
            n_k = r_k + 2'd1;
        end
    end

    // Datapath commands
    always_comb begin
        o_in_ready        = 1'b0;
        o_cmd.load        = 1'b0;
        o_cmd.state_op    = 1'b0;
        o_cmd.mul_src     = iirt2_pkg::MUL_B;
        o_cmd.coef_idx    = '0;
        o_cmd.acc_op      = iirt2_pkg::ACC_HOLD;
        o_cmd.z_idx       = '0;
        o_cmd.z_wr        = 1'b0;
        o_cmd.z_wr_idx    = r_k;
        o_cmd.y_latch     = 1'b0;
        o_cmd.out_load    = 1'b0;
        case (r_state)
            iirt2_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            iirt2_pkg::ST_STATE_OP: begin
                o_cmd.state_op = 1'b1;
            end
            // b0*x, preload z0
            iirt2_pkg::ST_Y_MUL: begin
                o_cmd.coef_idx = 3'd0;
                o_cmd.acc_op   = iirt2_pkg::ACC_LOAD_Z;
                o_cmd.z_idx    = 3'd0;
            end
            iirt2_pkg::ST_Y_ADD: begin
                o_cmd.acc_op = iirt2_pkg::ACC_ADD;
            end
            // Round the output, start b1*x and preload z1
            iirt2_pkg::ST_Y_RND: begin
                o_cmd.y_latch  = 1'b1;
                o_cmd.coef_idx = 3'd1;
                o_cmd.acc_op   = iirt2_pkg::ACC_LOAD_Z;
                o_cmd.z_idx    = 3'd1;
            end
            iirt2_pkg::ST_ADD_B: begin
                o_cmd.acc_op   = iirt2_pkg::ACC_ADD;
                o_cmd.mul_src  = iirt2_pkg::MUL_A;
                o_cmd.coef_idx = 3'(r_k) + 3'd1;
            end
            iirt2_pkg::ST_SUB_A: begin
                o_cmd.acc_op   = iirt2_pkg::ACC_SUB;
                o_cmd.coef_idx = 3'(r_k) + 3'd2;
            end
            // Store z[k], then start on z[k+1]
            iirt2_pkg::ST_WR_Z: begin
                o_cmd.z_wr     = 1'b1;
                o_cmd.acc_op   = iirt2_pkg::ACC_LOAD_Z_ADD;
                o_cmd.z_idx    = 3'(r_k) + 3'd2;
                o_cmd.mul_src  = iirt2_pkg::MUL_A;
                o_cmd.coef_idx = 3'(r_k) + 3'd2;
            end
            iirt2_pkg::ST_DONE: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

### sv/iirt2_dp.sv
// Datapath of the IIR filter: coefficients, delay states, shared multiplier, output register.
module iirt2_dp #(
    parameter int ORDER = 3
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  iirt2_pkg::t_dp_cmd                   i_cmd,
    output iirt2_pkg::t_dp_status                o_status,
    input  logic [iirt2_pkg::OP_W-1:0]           i_op,
    input  logic [iirt2_pkg::IN_TDATA_W-1:0]     i_in_data,
    input  logic                                 i_cfg_we,
    input  logic [iirt2_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [iirt2_pkg::COEF_W-1:0]         i_cfg_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [iirt2_pkg::OUT_TDATA_W-1:0]    o_out_data,
    output logic                                 o_out_sat
);

    localparam int ZA_W = (ORDER > 1) ? $clog2(ORDER) : 1;
    localparam logic [iirt2_pkg::CIDX_W-1:0] Z_DEPTH = iirt2_pkg::CIDX_W'(ORDER);

    // Captured item
    logic [iirt2_pkg::OP_W-1:0]         r_op;
    logic signed [iirt2_pkg::X_W-1:0]   r_x;
    logic [iirt2_pkg::IDX_W-1:0]        r_idx;
    logic signed [iirt2_pkg::ST_W-1:0]  r_sv;

    // Coefficients; a0 is one and has no register
    logic signed [iirt2_pkg::COEF_W-1:0] r_coef_b [0:3];
    logic signed [iirt2_pkg::COEF_W-1:0] r_coef_a [1:3];

    logic signed [iirt2_pkg::ST_W-1:0]   r_z [0:ORDER-1];

    iirt2_pkg::t_prod                    r_p;
    iirt2_pkg::t_acc                     r_acc, n_acc;
    logic signed [iirt2_pkg::X_W-1:0]    r_y;
    logic signed [iirt2_pkg::ST_W-1:0]   r_sout;
    logic                                r_sat;

    logic                                r_out_valid;
    logic [iirt2_pkg::OUT_TDATA_W-1:0]   r_out_data;
    logic                                r_out_sat;

    logic signed [iirt2_pkg::COEF_W-1:0] w_coef;
    logic signed [iirt2_pkg::X_W-1:0]    w_opnd;
    iirt2_pkg::t_prod                    w_prod;
    logic [iirt2_pkg::CIDX_W-1:0]        w_rd_addr;
    logic                                w_rd_ok;
    logic signed [iirt2_pkg::ST_W-1:0]   w_zrd;
    logic [iirt2_pkg::IDX_W-1:0]         w_wr_addr;
    logic                                w_wr_ok;
    iirt2_pkg::t_acc                     w_rnd;
    iirt2_pkg::t_acc                     w_yfull;
    logic signed [iirt2_pkg::X_W-1:0]    w_y;
    logic                                w_y_clip;
    logic signed [iirt2_pkg::ST_W-1:0]   w_zclip;
    logic                                w_z_clip;

    // Pick the coefficient; indexes with no register (past 3, or a0) read as zero
    always_comb begin
        w_coef = '0;
        case (i_cmd.mul_src)
            iirt2_pkg::MUL_B: begin
                if (i_cmd.coef_idx inside {[3'd0:3'd3]}) begin
                    w_coef = r_coef_b[i_cmd.coef_idx[1:0]];
                end
            end
            iirt2_pkg::MUL_A: begin
                if (i_cmd.coef_idx inside {[3'd1:3'd3]}) begin
                    w_coef = r_coef_a[i_cmd.coef_idx[1:0]];
                end
            end
            default: w_coef = '0;
        endcase
    end

    assign w_opnd = (i_cmd.mul_src == iirt2_pkg::MUL_B) ? r_x : r_y;
    assign w_prod = iirt2_pkg::t_prod'(w_coef) * iirt2_pkg::t_prod'(w_opnd);

    // Single read port on the delay states; beyond the order reads zero
    assign w_rd_addr = i_cmd.state_op ? iirt2_pkg::CIDX_W'(r_idx) : i_cmd.z_idx;
    assign w_rd_ok   = (w_rd_addr < Z_DEPTH);
    assign w_zrd     = w_rd_ok ? r_z[w_rd_addr[ZA_W-1:0]] : '0;

    assign w_wr_addr = i_cmd.state_op ? r_idx : i_cmd.z_wr_idx;
    assign w_wr_ok   = (iirt2_pkg::CIDX_W'(w_wr_addr) < Z_DEPTH);

    // Round half up, then clip to 16 bits
    assign w_rnd    = r_acc + iirt2_pkg::RND_HALF;
    assign w_yfull  = w_rnd >>> iirt2_pkg::FRAC_W;
    always_comb begin
        w_y_clip = 1'b0;
        w_y      = w_yfull[iirt2_pkg::X_W-1:0];
        if (w_yfull > iirt2_pkg::Y_MAX) begin
            w_y      = 16'sh7FFF;
            w_y_clip = 1'b1;
        end else if (w_yfull < iirt2_pkg::Y_MIN) begin
            w_y      = 16'sh8000;
            w_y_clip = 1'b1;
        end
    end

    // Clip a new state to 48 bits
    always_comb begin
        w_z_clip = 1'b0;
        w_zclip  = r_acc[iirt2_pkg::ST_W-1:0];
        if (r_acc > iirt2_pkg::ST_MAX) begin
            w_zclip  = 48'sh7FFF_FFFF_FFFF;
            w_z_clip = 1'b1;
        end else if (r_acc < iirt2_pkg::ST_MIN) begin
            w_zclip  = 48'sh8000_0000_0000;
            w_z_clip = 1'b1;
        end
    end

    // Accumulator next value
    always_comb begin
        n_acc = r_acc;
        case (i_cmd.acc_op)
            iirt2_pkg::ACC_HOLD:       n_acc = r_acc;
            iirt2_pkg::ACC_LOAD_Z:     n_acc = iirt2_pkg::t_acc'(w_zrd);
            iirt2_pkg::ACC_LOAD_Z_ADD: n_acc = iirt2_pkg::t_acc'(w_zrd)
                                               + iirt2_pkg::t_acc'(r_p);
            iirt2_pkg::ACC_ADD:        n_acc = r_acc + iirt2_pkg::t_acc'(r_p);
            iirt2_pkg::ACC_SUB:        n_acc = r_acc - iirt2_pkg::t_acc'(r_p);
            default:                   n_acc = r_acc;
        endcase
    end

    // Capture the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_x   <= i_in_data[iirt2_pkg::IN_X_LSB +: iirt2_pkg::X_W];
            r_idx <= i_in_data[iirt2_pkg::IN_IDX_LSB +: iirt2_pkg::IDX_W];
            r_sv  <= i_in_data[iirt2_pkg::IN_SV_LSB +: iirt2_pkg::ST_W];
        end
    end

    // Coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_b[0] <= iirt2_pkg::COEF_ONE;
            r_coef_b[1] <= '0;
            r_coef_b[2] <= '0;
            r_coef_b[3] <= '0;
            r_coef_a[1] <= '0;
            r_coef_a[2] <= '0;
            r_coef_a[3] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                iirt2_pkg::CFG_B0: r_coef_b[0] <= i_cfg_data;
                iirt2_pkg::CFG_B1: r_coef_b[1] <= i_cfg_data;
                iirt2_pkg::CFG_B2: r_coef_b[2] <= i_cfg_data;
                iirt2_pkg::CFG_B3: r_coef_b[3] <= i_cfg_data;
                iirt2_pkg::CFG_A1: r_coef_a[1] <= i_cfg_data;
                iirt2_pkg::CFG_A2: r_coef_a[2] <= i_cfg_data;
                iirt2_pkg::CFG_A3: r_coef_a[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Product and accumulator registers
    always_ff @(posedge i_clk) begin
        r_p   <= w_prod;
        r_acc <= n_acc;
    end

    // Delay states: filter update or direct write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ORDER; i++) begin
                r_z[i] <= '0;
            end
        end else if (w_wr_ok) begin
            if (i_cmd.z_wr) begin
                r_z[w_wr_addr[ZA_W-1:0]] <= w_zclip;
            end else if (i_cmd.state_op && r_op == iirt2_pkg::OP_WRITE) begin
                r_z[w_wr_addr[ZA_W-1:0]] <= r_sv;
            end
        end
    end

    // Result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_y    <= '0;
            r_sout <= '0;
            r_sat  <= 1'b0;
        end else if (i_cmd.state_op) begin
            if (r_op == iirt2_pkg::OP_READ) begin
                r_sout <= w_zrd;
            end
        end else if (i_cmd.y_latch) begin
            r_y   <= w_y;
            r_sat <= r_sat | w_y_clip;
        end else if (i_cmd.z_wr) begin
            r_sat <= r_sat | w_z_clip;
        end
    end

    // Output register: load when free, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= iirt2_pkg::OUT_TDATA_W'({r_sout, r_y});
            r_out_sat  <= r_sat;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;
    assign o_out_sat         = r_out_sat;

endmodule

### sv/iir_filter_tdf2_top.sv
// Order-3 transposed direct form II IIR filter with stream ports and a coefficient write port.
//
// Input stream (s_axis): tuser carries the operation (filter a sample, write a
// delay state, read a delay state); tdata carries sample, state index and state
// value. Output stream (m_axis): one item per input item, with the filtered
// sample, the read-back state and a saturation flag.
// Coefficient port: i_cfg_index selects b0..b3, a1..a3 (Q4.28); o_cfg_ready is
// always high. Write coefficients only while no item is in flight.
// Datapath: one shared 32x16 multiplier and one accumulator are stepped by the
// controller. A filter item steps through Y_MUL, Y_ADD, Y_RND and ADD_B, then
// SUB_A and WR_Z once per delay state, and DONE loads its result into the
// output register. State writes and reads step through STATE_OP and then DONE.
// One item is worked at a time. A finished result sits in the output register;
// the block accepts the next item while it waits, and holds that item's result
// until the register is taken.
// Reset (synchronous, active low) clears the delay states, sets b0 to one and
// the other coefficients to zero, and empties the output register.
module iir_filter_tdf2_top #(
    parameter int ORDER = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] sample_in, [17:16] state_index, [65:18] state_value, [71:66] zero
    input  logic [iirt2_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] operation
    input  logic [iirt2_pkg::OP_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] sample_out, [63:16] state_out
    output logic [iirt2_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [0] saturated
    output logic [0:0]                          m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [iirt2_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [iirt2_pkg::COEF_W-1:0]        i_cfg_data
);

    iirt2_pkg::t_dp_cmd    w_cmd;
    iirt2_pkg::t_dp_status w_status;
    logic                  w_out_sat;

    assign o_cfg_ready     = 1'b1;
    assign m_axis_tuser[0] = w_out_sat;

    iirt2_ctrl #(
        .ORDER (ORDER)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_op       (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    iirt2_dp #(
        .ORDER (ORDER)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_op        (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_sat   (w_out_sat)
    );

endmodule

### sv/iirt2_checker.sv
// Port-level checker for the IIR filter block, bound to the top level.
`include "iir_filter_tdf2_top_assert.svh"

module iirt2_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [iirt2_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input logic [0:0]                          m_axis_tuser
);

    logic w_in_acc;

    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    // Hold a stalled result
    `IIRT2_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "stalled result changed")

    // One item in work at a time
    `IIRT2_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n,
        w_in_acc, !s_axis_tready,
        "input accepted while an item is in work")

    // No result in the cycle right after an accept into an empty output
    `IIRT2_ASSERT_NEXT(a_min_latency, i_clk, i_rst_n,
        w_in_acc && !m_axis_tvalid, !m_axis_tvalid,
        "result appeared too early")

    // A state read carries no sample and no saturation
    `IIRT2_ASSERT_SAME(a_read_clean, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tdata[63:16] != 48'd0),
        (m_axis_tdata[15:0] == 16'd0) && !m_axis_tuser[0],
        "state read result mixed with filter fields")

endmodule

bind iir_filter_tdf2_top iirt2_checker u_iirt2_checker (.*);

### bench/iir_filter_tdf2_checker.sv
// Checker for the order-3 IIR filter: tracks coefficients and delay states, predicts and compares.
`timescale 1ns / 1ps

module iir_filter_tdf2_checker #(
    parameter int ORDER = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [iirt2_pkg::IN_TDATA_W-1:0]    i_in_data,
    input  logic [iirt2_pkg::OP_W-1:0]          i_in_op,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [iirt2_pkg::OUT_TDATA_W-1:0]   i_out_data,
    input  logic [0:0]                          i_out_sat,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [iirt2_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [iirt2_pkg::COEF_W-1:0]        i_cfg_data,
    output int                                  o_pending,
    output int                                  o_fail_count
);
    import iirt2_pkg::*;

    localparam longint Y_HI     = 32767;
    localparam longint Y_LO     = -32768;
    localparam longint STATE_HI = (longint'(1) <<< (ST_W - 1)) - 1;
    localparam longint STATE_LO = -(longint'(1) <<< (ST_W - 1));
    localparam longint HALF_LSB = longint'(1) <<< (FRAC_W - 1);

    typedef struct packed {
        logic signed [X_W-1:0]  sample;
        logic signed [ST_W-1:0] state;
        logic                   sat;
    } filt_result_t;

    // Model copy of the coefficients and the delay line
    logic signed [COEF_W-1:0] ff_coef [0:3];
    logic signed [COEF_W-1:0] fb_coef [1:3];
    logic signed [ST_W-1:0]   delay_line [0:2];

    filt_result_t pending_outputs [$];
    int mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    // Apply one coefficient write
    function automatic void load_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
        case (idx)
            CFG_B0: ff_coef[0] = val;
            CFG_B1: ff_coef[1] = val;
            CFG_B2: ff_coef[2] = val;
            CFG_B3: ff_coef[3] = val;
            CFG_A1: fb_coef[1] = val;
            CFG_A2: fb_coef[2] = val;
            CFG_A3: fb_coef[3] = val;
            default: ;
        endcase
    endfunction

    // Work out one item's result and advance the delay line
    function automatic filt_result_t filter_step(logic [OP_W-1:0] op,
                                                 logic [IN_TDATA_W-1:0] data);
        filt_result_t res;
        logic signed [X_W-1:0]  x;
        logic [IDX_W-1:0]       idx;
        logic signed [ST_W-1:0] wr_val;
        longint acc, y, t, nxt;
        x      = data[IN_X_LSB +: X_W];
        idx    = data[IN_IDX_LSB +: IDX_W];
        wr_val = data[IN_SV_LSB +: ST_W];
        res    = '0;
        case (op)
            OP_FILTER: begin
                acc = longint'(ff_coef[0]) * longint'(x) + longint'(delay_line[0]);
                y   = (acc + HALF_LSB) >>> FRAC_W;
                if (y > Y_HI) begin
                    y = Y_HI;
                    res.sat = 1'b1;
                end
                if (y < Y_LO) begin
                    y = Y_LO;
                    res.sat = 1'b1;
                end
                // Ascending k still sees the old value of state k+1
                for (int k = 0; k < ORDER; k++) begin
                    nxt = 0;
                    if (k + 1 < ORDER)
                        nxt = delay_line[k + 1];
                    t = longint'(ff_coef[k + 1]) * longint'(x)
                        - longint'(fb_coef[k + 1]) * y + nxt;
                    if (t > STATE_HI) begin
                        t = STATE_HI;
                        res.sat = 1'b1;
                    end
                    if (t < STATE_LO) begin
                        t = STATE_LO;
                        res.sat = 1'b1;
                    end
                    delay_line[k] = t[ST_W-1:0];
                end
                res.sample = y[X_W-1:0];
            end
            OP_WRITE: begin
                if (idx < ORDER)
                    delay_line[idx] = wr_val;
            end
            OP_READ: begin
                if (idx < ORDER)
                    res.state = delay_line[idx];
            end
            default: ;
        endcase
        return res;
    endfunction

    // Compare results, follow coefficient writes, predict accepted items
    always @(posedge i_clk) begin : monitor
        filt_result_t want;
        logic signed [X_W-1:0]  got_sample;
        logic signed [ST_W-1:0] got_state;
        got_sample = i_out_data[0 +: X_W];
        got_state  = i_out_data[X_W +: ST_W];
        if (!i_rst_n) begin
            ff_coef[0] = COEF_ONE;
            for (int k = 1; k <= 3; k++) begin
                ff_coef[k] = '0;
                fb_coef[k] = '0;
            end
            for (int k = 0; k < 3; k++)
                delay_line[k] = '0;
            pending_outputs.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_outputs.size() == 0) begin
                    $display("%0t: output item with nothing expected: sample_out %0d state_out %0d",
                             $time, got_sample, got_state);
                    mismatch_count++;
                end else begin
                    want = pending_outputs.pop_front();
                    if (got_sample !== want.sample) begin
                        $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                                 $time, $signed(want.sample), got_sample);
                        mismatch_count++;
                    end
                    if (got_state !== want.state) begin
                        $display("%0t: state_out mismatch: expected %0d, actual %0d",
                                 $time, $signed(want.state), got_state);
                        mismatch_count++;
                    end
                    if (i_out_sat[0] !== want.sat) begin
                        $display("%0t: saturated mismatch: expected %0b, actual %0b",
                                 $time, want.sat, i_out_sat[0]);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                load_coef(i_cfg_index, i_cfg_data);
            if (i_in_valid && i_in_ready)
                pending_outputs.insert(pending_outputs.size(),
                                       filter_step(i_in_op, i_in_data));
        end
        o_pending <= pending_outputs.size();
    end

endmodule

### bench/iir_filter_tdf2_top_tb.sv
// Testbench top for the order-3 IIR filter: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module iir_filter_tdf2_top_tb;
    import iirt2_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic signed [ST_W-1:0]   STATE_TOP    = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [ST_W-1:0]   STATE_BOTTOM = 48'sh8000_0000_0000;
    localparam logic signed [COEF_W-1:0] COEF_TOP     = 32'sh7FFF_FFFF;
    localparam logic signed [COEF_W-1:0] COEF_BOTTOM  = 32'sh8000_0000;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 16;
    localparam int PHASE_ITEMS    = 80;

    typedef enum {COEF_GENTLE, COEF_WILD, COEF_EDGE} coef_mode_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_TDATA_W-1:0]     s_axis_tdata;
    logic [OP_W-1:0]           s_axis_tuser;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_TDATA_W-1:0]    m_axis_tdata;
    logic [0:0]                m_axis_tuser;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [COEF_W-1:0]         i_cfg_data;

    int pending_count;
    int fail_count;
    int idle_cycles = 0;
    int src_calm = 0;
    int sink_calm = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    iir_filter_tdf2_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    iir_filter_tdf2_checker u_filter_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_op      (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_sat    (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending_count),
        .o_fail_count (fail_count)
    );

    // Draw a wait per item; now and then run a stretch with no waits at all
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(4, 24);
            return 0;
        end
        if ($urandom_range(0, 1) == 0)
            return $urandom_range(0, 3);
        return $urandom_range(0, 18);
    endfunction

    function automatic logic signed [X_W-1:0] rand_sample();
        case ($urandom_range(0, 11))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return -16'sd1;
            default: return X_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [ST_W-1:0] rand_state();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return STATE_TOP;
            1: return STATE_BOTTOM;
            2: return '0;
            3, 4, 5: return ST_W'(longint'(rand_sample()) <<< FRAC_W);
            default: return raw[ST_W-1:0];
        endcase
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_coef(coef_mode_t mode);
        case (mode)
            COEF_GENTLE: return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
            COEF_EDGE: begin
                case ($urandom_range(0, 4))
                    0: return COEF_TOP;
                    1: return COEF_BOTTOM;
                    2: return COEF_ONE;
                    3: return -COEF_ONE;
                    default: return '0;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Offer one item after a random wait and hold it until taken
    task automatic send_item(logic [OP_W-1:0] op, logic signed [X_W-1:0] x,
                             logic [IDX_W-1:0] idx, logic signed [ST_W-1:0] val);
        logic [IN_TDATA_W-1:0] word;
        int gap;
        word = '0;
        word[IN_X_LSB +: X_W]     = x;
        word[IN_IDX_LSB +: IDX_W] = idx;
        word[IN_SV_LSB +: ST_W]   = val;
        gap = draw_wait(src_calm);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
    endtask

    task automatic set_coefs(logic [COEF_W-1:0] b0, logic [COEF_W-1:0] b1,
                             logic [COEF_W-1:0] b2, logic [COEF_W-1:0] b3,
                             logic [COEF_W-1:0] a1, logic [COEF_W-1:0] a2,
                             logic [COEF_W-1:0] a3);
        write_reg(CFG_B0, b0);
        write_reg(CFG_B1, b1);
        write_reg(CFG_B2, b2);
        write_reg(CFG_B3, b3);
        write_reg(CFG_A1, a1);
        write_reg(CFG_A2, a2);
        write_reg(CFG_A3, a3);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering items and hold until every expected result is back
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge i_clk);
    endtask

    // Mostly filter items, with state writes, reads and unused operations mixed in
    task automatic random_items(int count);
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                send_item(OP_FILTER, rand_sample(), IDX_W'($urandom), rand_state());
            else if (pick < 77)
                send_item(OP_WRITE, rand_sample(), IDX_W'($urandom_range(0, 3)), rand_state());
            else if (pick < 95)
                send_item(OP_READ, rand_sample(), IDX_W'($urandom_range(0, 3)), rand_state());
            else
                send_item(OP_UNUSED, rand_sample(), IDX_W'($urandom), rand_state());
        end
    endtask

    // Result sink: random stall per item, then hold tready until an item is taken
    initial begin : result_sink
        int gap;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = draw_wait(sink_calm);
            repeat (gap) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Watchdog: end the run when no channel has moved for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        coef_mode_t modes [6];
        coef_mode_t mode;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        modes = '{COEF_GENTLE, COEF_WILD, COEF_GENTLE, COEF_EDGE, COEF_GENTLE, COEF_WILD};
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset coefficients: pass-through, state reads, out-of-range index, unused op
        send_item(OP_READ, 16'sd0, 2'd0, '0);
        send_item(OP_READ, 16'sd0, 2'd1, '0);
        send_item(OP_READ, 16'sd0, 2'd2, '0);
        send_item(OP_UNUSED, 16'sh7FFF, 2'd3, STATE_TOP);
        send_item(OP_FILTER, 16'sh7FFF, 2'd0, '0);
        send_item(OP_FILTER, 16'sh8000, 2'd0, '0);
        send_item(OP_FILTER, -16'sd1, 2'd0, '0);
        // Output clips when the first state is driven to either end
        send_item(OP_WRITE, 16'sd0, 2'd0, STATE_TOP);
        send_item(OP_FILTER, 16'sh7FFF, 2'd0, '0);
        send_item(OP_WRITE, 16'sd0, 2'd0, STATE_BOTTOM);
        send_item(OP_FILTER, 16'sh8000, 2'd0, '0);
        // Write to an index past the order is dropped; its read returns zero
        send_item(OP_WRITE, 16'sd0, 2'd3, STATE_TOP);
        send_item(OP_READ, 16'sd0, 2'd3, '0);
        send_item(OP_WRITE, 16'sd0, 2'd2, STATE_BOTTOM);
        send_item(OP_READ, 16'sd0, 2'd2, '0);
        wait_idle();

        // Largest feed-forward, most negative feedback: states clip high
        set_coefs(COEF_TOP, COEF_TOP, COEF_TOP, COEF_TOP,
                  COEF_BOTTOM, COEF_BOTTOM, COEF_BOTTOM);
        send_item(OP_FILTER, 16'sh7FFF, 2'd0, '0);
        send_item(OP_FILTER, 16'sh7FFF, 2'd0, '0);
        send_item(OP_READ, 16'sd0, 2'd1, '0);
        wait_idle();

        // All coefficients at the bottom end
        set_coefs(COEF_BOTTOM, COEF_BOTTOM, COEF_BOTTOM, COEF_BOTTOM,
                  COEF_BOTTOM, COEF_BOTTOM, COEF_BOTTOM);
        send_item(OP_FILTER, 16'sh8000, 2'd0, '0);
        send_item(OP_FILTER, 16'sh7FFF, 2'd0, '0);
        send_item(OP_READ, 16'sd0, 2'd0, '0);
        wait_idle();

        // Random phases, each with fresh coefficients
        for (int p = 0; p < 6; p++) begin
            mode = modes[p];
            set_coefs(rand_coef(mode), rand_coef(mode), rand_coef(mode), rand_coef(mode),
                      rand_coef(mode), rand_coef(mode), rand_coef(mode));
            random_items(PHASE_ITEMS);
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/iirt2_pkg.sv
sv/iirt2_ctrl.sv
sv/iirt2_dp.sv
sv/iir_filter_tdf2_top.sv
sv/iirt2_checker.sv
bench/iir_filter_tdf2_checker.sv
bench/iir_filter_tdf2_top_tb.sv
